FILE: sv/cbd_pkg.sv
// package: constants, phase and status types, hex decode for the chunked body decoder
package cbd_pkg;

  localparam int SIZE_BITS = 32;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  typedef enum logic [3:0] {
    PH_SIZE,
    PH_SIZE_CR,
    PH_EXT,
    PH_EXT_CR,
    PH_DATA,
    PH_DATA_CR,
    PH_DATA_LF,
    PH_END,
    PH_ERR
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_BAD_SIZE,
    ST_NO_CRLF_SIZE,
    ST_DATA_SHORT,
    ST_NO_CRLF_DATA,
    ST_NO_TERM
  } status_t;

  typedef logic [SIZE_BITS-1:0] size_t;

  // {is_hex, value}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

FILE: sv/cbd_in_if.sv
// interface: input byte channel
interface cbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last;

  modport source (output valid, output in_byte, output last, input ready);
  modport sink   (input valid, input in_byte, input last, output ready);
endinterface

FILE: sv/cbd_out_if.sv
// interface: decoded result channel
interface cbd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       data_valid;
  logic       done_res;
  logic [2:0] status;

  modport source (output valid, output data_byte, output data_valid, output done_res,
                  output status, input ready);
  modport sink   (input valid, input data_byte, input data_valid, input done_res,
                  input status, output ready);
endinterface

FILE: sv/cbd_cfg_if.sv
// interface: configuration write channel for the chunked_mode register
interface cbd_cfg_if;
  logic valid;
  logic ready;
  logic chunked_mode;

  modport source (output valid, output chunked_mode, input ready);
  modport sink   (input valid, input chunked_mode, output ready);
endinterface

FILE: sv/chunked_body_decoder.sv
// Chunked transfer-coding body decoder, one byte per clock unless stalled.
//
// in_ch carries body bytes with a last flag; out_ch carries results:
// a payload byte (data_valid) and/or, for the last byte, done_res with a
// status code. Bytes of size lines, extensions, CRLFs and trailers make no
// result unless they are the last byte. cfg writes chunked_mode at any
// transaction (ready is always high); 0 passes every byte through.
// A byte is registered in the input register and decoded there; its
// result enters the output register as the byte moves on, which it does
// when out_ch is free or the byte makes no result.
// Throughput: one byte per clock unless a result waits on a stalled
// out_ch, set by the single decode step between the two registers; the
// parse state updates as a byte leaves, so the next byte follows at once.
// Reset: chunked_mode is 1, the parser waits for a size line, both
// registers are empty. After the last byte the parse state returns to
// that start point. When out_ch stalls with a result held, the input
// register keeps one more byte and then in_ch.ready drops; bytes that
// make no result still drain while the output is stalled.
module chunked_body_decoder (
  input  logic clk,
  input  logic rst,
  cbd_in_if.sink    in_ch,
  cbd_out_if.source out_ch,
  cbd_cfg_if.sink   cfg
);
  import cbd_pkg::*;

  logic       chunked_mode;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       s1_go;

  phase_t     phase, phase_step, phase_next;
  size_t      size, size_step, size_next;
  logic       digit_seen, digit_step, digit_seen_next;
  logic       bad_pend, bad_step, bad_pend_next;
  status_t    error_code, err_step, error_code_next;

  logic       res_data;
  status_t    res_status;
  logic       has_res;
  logic       out_free;
  logic [4:0] hex;
  size_t      size_dec;

  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_dvalid;
  logic       out_done;
  status_t    out_status;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      chunked_mode <= 1'b1;
    end else if (cfg.valid) begin
      chunked_mode <= cfg.chunked_mode;
    end
  end

  // input register
  assign out_free    = !out_valid || out_ch.ready;
  assign has_res     = res_data || s1_last;
  assign s1_go       = s1_valid && (!has_res || out_free);
  assign in_ch.ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte <= in_ch.in_byte;
      s1_last <= in_ch.last;
    end
  end

  assign hex      = hex_decode(s1_byte);
  assign size_dec = size - size_t'(1);

  // parse step for one byte
  always_comb begin
    phase_step = phase;
    size_step  = size;
    digit_step = digit_seen;
    bad_step   = bad_pend;
    err_step   = error_code;
    if (chunked_mode) begin
      unique case (phase)
        PH_SIZE: begin
          if (hex[4]) begin
            if (!bad_pend) begin
              if (size[SIZE_BITS-1 -: 4] != 4'd0) begin
                bad_step = 1'b1;
              end else begin
                size_step = {size[SIZE_BITS-5:0], hex[3:0]};
              end
            end
            digit_step = 1'b1;
          end else if (s1_byte == CH_SPACE || s1_byte == CH_TAB) begin
            if (digit_seen) bad_step = 1'b1;
          end else if (s1_byte == CH_SEMI) begin
            phase_step = PH_EXT;
          end else if (s1_byte == CH_CR) begin
            phase_step = PH_SIZE_CR;
          end else begin
            bad_step = 1'b1;
          end
        end
        PH_SIZE_CR, PH_EXT_CR: begin
          if (s1_byte == CH_LF) begin
            // end of size line
            if (bad_pend || !digit_seen) begin
              phase_step = PH_ERR;
              err_step   = ST_BAD_SIZE;
            end else if (size == '0) begin
              phase_step = PH_END;
            end else begin
              phase_step = PH_DATA;
            end
            digit_step = 1'b0;
            bad_step   = 1'b0;
          end else if (phase == PH_SIZE_CR) begin
            bad_step = 1'b1;
            if (s1_byte != CH_CR) phase_step = PH_SIZE;
          end else if (s1_byte != CH_CR) begin
            phase_step = PH_EXT;
          end
        end
        PH_EXT: begin
          if (s1_byte == CH_CR) phase_step = PH_EXT_CR;
        end
        PH_DATA: begin
          size_step = size_dec;
          if (size_dec == '0) phase_step = PH_DATA_CR;
        end
        PH_DATA_CR: begin
          if (s1_byte == CH_CR) begin
            phase_step = PH_DATA_LF;
          end else begin
            phase_step = PH_ERR;
            err_step   = ST_NO_CRLF_DATA;
          end
        end
        PH_DATA_LF: begin
          if (s1_byte == CH_LF) begin
            phase_step = PH_SIZE;
            size_step  = '0;
            digit_step = 1'b0;
            bad_step   = 1'b0;
          end else begin
            phase_step = PH_ERR;
            err_step   = ST_NO_CRLF_DATA;
          end
        end
        PH_END, PH_ERR: begin
        end
        default: begin
        end
      endcase
    end
  end

  // final next state: last byte returns the parser to its start
  always_comb begin
    if (s1_last) begin
      phase_next      = PH_SIZE;
      size_next       = '0;
      digit_seen_next = 1'b0;
      bad_pend_next   = 1'b0;
      error_code_next = ST_OK;
    end else begin
      phase_next      = phase_step;
      size_next       = size_step;
      digit_seen_next = digit_step;
      bad_pend_next   = bad_step;
      error_code_next = err_step;
    end
  end

  // result of this byte
  always_comb begin
    res_data   = !chunked_mode || phase == PH_DATA;
    res_status = ST_OK;
    if (chunked_mode && s1_last) begin
      unique case (phase_step)
        PH_ERR:                 res_status = err_step;
        PH_END:                 res_status = ST_OK;
        PH_DATA:                res_status = ST_DATA_SHORT;
        PH_DATA_CR, PH_DATA_LF: res_status = ST_NO_CRLF_DATA;
        PH_SIZE:                res_status = (phase == PH_DATA_LF) ? ST_NO_TERM
                                                                    : ST_NO_CRLF_SIZE;
        default:                res_status = ST_NO_CRLF_SIZE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_SIZE;
      size       <= '0;
      digit_seen <= 1'b0;
      bad_pend   <= 1'b0;
      error_code <= ST_OK;
    end else if (s1_go) begin
      phase      <= phase_next;
      size       <= size_next;
      digit_seen <= digit_seen_next;
      bad_pend   <= bad_pend_next;
      error_code <= error_code_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && has_res) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && has_res) begin
      out_byte   <= res_data ? s1_byte : 8'd0;
      out_dvalid <= res_data;
      out_done   <= s1_last;
      out_status <= res_status;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.data_byte  = out_byte;
  assign out_ch.data_valid = out_dvalid;
  assign out_ch.done_res   = out_done;
  assign out_ch.status     = out_status;

  a_res_has_content: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.data_valid || out_ch.done_res))
    else $error("result transaction with neither data nor done");

  a_err_code_set: assert property (@(posedge clk) disable iff (rst)
    phase == PH_ERR |-> error_code != ST_OK)
    else $error("error phase without an error code");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (s1_go && s1_last) |=> (phase == PH_SIZE && size == '0))
    else $error("parse state not cleared after last byte");

  a_data_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DATA |-> size != '0)
    else $error("data phase with zero remaining count");

endmodule
